@@ hdl/fpt_pkg.sv @@
// ----------------------------------------------------------------------------
// fpt_pkg: shared types and constants for the flow priority tagger
// Flow key layout, protocol and register codes, queue codes and FSM states.
// ----------------------------------------------------------------------------
package fpt_pkg;

    // configuration register indexes
    localparam logic [7:0] CFG_FIRST_LIMIT  = 8'd0;
    localparam logic [7:0] CFG_SECOND_LIMIT = 8'd1;

    localparam logic [15:0] FIRST_LIMIT_RST  = 16'd3;
    localparam logic [15:0] SECOND_LIMIT_RST = 16'd10;

    localparam logic [3:0] IP_VERSION_4 = 4'd4;
    localparam logic [7:0] PROTO_TCP    = 8'd6;
    localparam logic [7:0] PROTO_UDP    = 8'd17;

    localparam logic [1:0] QUEUE_ONE   = 2'd1;
    localparam logic [1:0] QUEUE_TWO   = 2'd2;
    localparam logic [1:0] QUEUE_THREE = 2'd3;

    // flow 5-tuple as stored in a way; ports = {source port, destination port}
    typedef struct packed {
        logic [7:0]  proto;
        logic [31:0] ports;
        logic [31:0] dst_addr;
        logic [31:0] src_addr;
    } t_key;

    localparam int KEY_W = $bits(t_key);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INDEX,
        ST_MATCH,
        ST_UPDATE
    } t_state;

endpackage

@@ hdl/fpt_ram.sv @@
// ----------------------------------------------------------------------------
// fpt_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module fpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/fpt_set_index.sv @@
// ----------------------------------------------------------------------------
// fpt_set_index: flow hash to set index
// Power-of-two set counts register the low bits; any other count
// divides by reciprocal multiplication, then one multiply-subtract gives the
// remainder, with the hash, quotient and remainder each registered.
// ----------------------------------------------------------------------------
module fpt_set_index #(
    parameter int SETS = 256
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic [31:0]                           i_hash,
    output logic                                  o_done,
    output logic [(SETS > 1 ? $clog2(SETS) : 1)-1:0] o_index
);

    localparam int IDX_W = SETS > 1 ? $clog2(SETS) : 1;

    generate
        if ((SETS & (SETS - 1)) == 0) begin : g_mask
            logic             r_done;
            logic [IDX_W-1:0] r_index;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_done <= 1'b0;
                end else begin
                    r_done <= i_start;
                end
                if (i_start) begin
                    r_index <= (SETS > 1) ? i_hash[IDX_W-1:0] : '0;
                end
            end

            assign o_done  = r_done;
            assign o_index = r_index;
        end else begin : g_rem
            // quotient = (hash * ceil(2^SH / SETS)) >> SH, exact for 32-bit hashes
            localparam int          SH     = 32 + IDX_W;
            localparam logic [63:0] ONE_SH = 64'd1 << SH;
            localparam logic [32:0] RECIP  =
                33'((ONE_SH + 64'(SETS) - 64'd1) / 64'(SETS));

            logic             r_v1;
            logic             r_v2;
            logic             r_done;
            logic [31:0]      r_hash;
            logic [31:0]      r_quot;
            logic [IDX_W-1:0] r_rem;
            logic [64:0]      prod;
            logic [31:0]      quot;
            logic [31:0]      back;
            logic [31:0]      diff;

            assign prod = 65'(r_hash) * 65'(RECIP);
            assign quot = 32'(prod >> SH);
            assign back = r_quot * 32'(SETS);
            assign diff = r_hash - back;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v1   <= 1'b0;
                    r_v2   <= 1'b0;
                    r_done <= 1'b0;
                end else begin
                    r_v1   <= i_start;
                    r_v2   <= r_v1;
                    r_done <= r_v2;
                end
                if (i_start) begin
                    r_hash <= i_hash;
                end
                if (r_v1) begin
                    r_quot <= quot;
                end
                if (r_v2) begin
                    r_rem <= diff[IDX_W-1:0];
                end
            end

            assign o_done  = r_done;
            assign o_index = r_rem;
        end
    endgenerate

endmodule

@@ hdl/flow_priority_tagger_top.sv @@
// ----------------------------------------------------------------------------
// flow_priority_tagger_top: per-flow packet counting and queue tagging
// Set-associative flow table in one RAM; count selects a priority queue.
// ----------------------------------------------------------------------------
// Usage
//   s_axis: one request per packet, parsed header fields in tdata.
//     Non-IPv4 requests are taken and give no result.
//   m_axis: one result per IPv4 request: queue, packet count, full flag.
//   cfg: register writes (0 first limit, 1 second limit), always ready;
//     write only while the block is idle.
// Sequence
//   An IPv4 request passes accept, index, RAM read and update before the
//   next accept; m_axis_tvalid is registered at the update. Set counts
//   other than a power of two go through the reciprocal unit that folds
//   the hash. Rate is set by the read-modify-write of one table row per
//   request.
// Reset
//   A clearing pass writes every row to zero with s_axis_tready low;
//   cfg writes are still taken.
// Stall
//   The result waits in the output register; a request is processed up to
//   its update, which holds until the output register is free.
// ----------------------------------------------------------------------------
module flow_priority_tagger_top
    import fpt_pkg::*;
#(
    parameter int TABLE_SETS = 256,
    parameter int TABLE_WAYS = 4,
    parameter int COUNT_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // request stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [3:0] ip_version, [11:4] protocol, [43:12] src_addr, [75:44] dst_addr,
    // [91:76] sport, [107:92] dport, [111:108] zero
    input  logic [111:0] s_axis_tdata,
    // result stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [1:0] queue_level, [17:2] pkt_count, [18] table_full, [23:19] zero
    output logic [23:0]  m_axis_tdata,
    // configuration writes
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [7:0]   i_cfg_addr,
    input  logic [15:0]  i_cfg_data
);

    localparam int IDX_W   = TABLE_SETS > 1 ? $clog2(TABLE_SETS) : 1;
    localparam int WAY_W   = TABLE_WAYS > 1 ? $clog2(TABLE_WAYS) : 1;
    // way entry: {valid, count, key}
    localparam int ENTRY_W = KEY_W + COUNT_BITS + 1;
    localparam int ROW_W   = TABLE_WAYS * ENTRY_W;
    localparam int CMP_W   = COUNT_BITS > 16 ? COUNT_BITS : 16;

    t_state r_state, n_state;

    logic [15:0] r_first_limit;
    logic [15:0] r_second_limit;

    // request fields
    logic [3:0]  in_ver;
    logic [7:0]  in_proto;
    logic [31:0] in_src, in_dst;
    logic [15:0] in_sport, in_dport;
    logic        in_l4;
    logic [15:0] in_sport_m, in_dport_m;
    logic [31:0] in_hash;
    logic        s_accept;
    logic        is_v4;

    t_key        r_key;
    logic [IDX_W-1:0] r_set;
    logic [IDX_W-1:0] r_clr_idx;
    logic        clr_last;

    logic        idx_done;
    logic [IDX_W-1:0] idx_index;

    // table RAM
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [ROW_W-1:0] ram_wdata;
    logic [ROW_W-1:0] rd_row;

    // lookup results
    logic                  m_hit, m_free;
    logic [WAY_W-1:0]      m_hit_way, m_free_way;
    logic [COUNT_BITS-1:0] m_hit_count;
    logic                  r_hit, r_free;
    logic [WAY_W-1:0]      r_hit_way, r_free_way;
    logic [COUNT_BITS-1:0] r_hit_count;

    // update
    logic [COUNT_BITS-1:0] inc_count, res_count;
    logic [CMP_W-1:0]      cnt_ext;
    logic [15:0]           pkt_count;
    logic [1:0]            queue;
    logic [ROW_W-1:0]      n_row;
    logic                  out_free;
    logic                  do_update;

    logic        r_out_valid;
    logic [23:0] r_out_data;

    // ---------------------------------------------------------------- input
    assign in_ver   = s_axis_tdata[3:0];
    assign in_proto = s_axis_tdata[11:4];
    assign in_src   = s_axis_tdata[43:12];
    assign in_dst   = s_axis_tdata[75:44];
    assign in_sport = s_axis_tdata[91:76];
    assign in_dport = s_axis_tdata[107:92];

    // ports only count for TCP and UDP
    assign in_l4      = (in_proto == PROTO_TCP) || (in_proto == PROTO_UDP);
    assign in_sport_m = in_l4 ? in_sport : 16'd0;
    assign in_dport_m = in_l4 ? in_dport : 16'd0;

    assign in_hash = in_src ^ in_dst ^ {15'd0, in_sport_m, 1'b0}
                   ^ {14'd0, in_dport_m, 2'b00} ^ {24'd0, in_proto};

    assign s_axis_tready = (r_state == ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign is_v4         = (in_ver == IP_VERSION_4);

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_key.proto    <= in_proto;
            r_key.ports    <= {in_sport_m, in_dport_m};
            r_key.dst_addr <= in_dst;
            r_key.src_addr <= in_src;
        end
        if (idx_done) begin
            r_set <= idx_index;
        end
    end

    fpt_set_index #(
        .SETS (TABLE_SETS)
    ) u_set_index (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (s_accept && is_v4),
        .i_hash  (in_hash),
        .o_done  (idx_done),
        .o_index (idx_index)
    );

    // ---------------------------------------------------------------- config
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_limit  <= FIRST_LIMIT_RST;
            r_second_limit <= SECOND_LIMIT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_addr)
                CFG_FIRST_LIMIT:  r_first_limit  <= i_cfg_data;
                CFG_SECOND_LIMIT: r_second_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------- table
    assign clr_last  = (r_clr_idx == IDX_W'(TABLE_SETS - 1));
    assign ram_we    = (r_state == ST_CLEAR) || do_update;
    assign ram_waddr = (r_state == ST_CLEAR) ? r_clr_idx : r_set;
    assign ram_wdata = (r_state == ST_CLEAR) ? '0 : n_row;

    fpt_ram #(
        .WIDTH (ROW_W),
        .DEPTH (TABLE_SETS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (idx_done),
        .i_raddr (idx_index),
        .o_rdata (rd_row)
    );

    // compare all ways of the row; lowest way wins on both hit and free
    always_comb begin
        logic [ENTRY_W-1:0] ent;
        m_hit       = 1'b0;
        m_free      = 1'b0;
        m_hit_way   = '0;
        m_free_way  = '0;
        m_hit_count = '0;
        for (int w = TABLE_WAYS - 1; w >= 0; w--) begin
            ent = rd_row[w*ENTRY_W +: ENTRY_W];
            if (ent[ENTRY_W-1]) begin
                if (ent[KEY_W-1:0] == r_key) begin
                    m_hit       = 1'b1;
                    m_hit_way   = WAY_W'(w);
                    m_hit_count = ent[KEY_W +: COUNT_BITS];
                end
            end else begin
                m_free     = 1'b1;
                m_free_way = WAY_W'(w);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_MATCH) begin
            r_hit       <= m_hit;
            r_free      <= m_free;
            r_hit_way   <= m_hit_way;
            r_free_way  <= m_free_way;
            r_hit_count <= m_hit_count;
        end
    end

    // saturating count, new row image
    always_comb begin
        inc_count = (r_hit_count == '1) ? r_hit_count : r_hit_count + 1'b1;
        res_count = r_hit ? inc_count : COUNT_BITS'(1);
        cnt_ext   = CMP_W'(res_count);
        pkt_count = (cnt_ext > CMP_W'(16'hFFFF)) ? 16'hFFFF : cnt_ext[15:0];
        if (cnt_ext <= CMP_W'(r_first_limit)) begin
            queue = QUEUE_ONE;
        end else if (cnt_ext <= CMP_W'(r_second_limit)) begin
            queue = QUEUE_TWO;
        end else begin
            queue = QUEUE_THREE;
        end
        n_row = rd_row;
        if (r_hit) begin
            n_row[r_hit_way*ENTRY_W + KEY_W +: COUNT_BITS] = inc_count;
        end else if (r_free) begin
            n_row[r_free_way*ENTRY_W +: ENTRY_W] = {1'b1, COUNT_BITS'(1), r_key};
        end
    end

    assign out_free  = !r_out_valid || m_axis_tready;
    assign do_update = (r_state == ST_UPDATE) && out_free && (r_hit || r_free);

    // ---------------------------------------------------------------- output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_UPDATE) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if ((r_state == ST_UPDATE) && out_free) begin
            r_out_data <= {5'd0, !(r_hit || r_free), pkt_count, queue};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // ---------------------------------------------------------------- control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_idx <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR:  if (clr_last) n_state = ST_IDLE;
            ST_IDLE:   if (s_accept && is_v4) n_state = ST_INDEX;
            ST_INDEX:  if (idx_done) n_state = ST_MATCH;
            ST_MATCH:  n_state = ST_UPDATE;
            ST_UPDATE: if (out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

endmodule
